/* sv/wsd_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none

package wsd_pkg;

  localparam int unsigned ByteW = 8;
  localparam int unsigned OpcW  = 4;
  localparam int unsigned LenW  = 64;

  localparam logic [6:0] LEN_EXT16 = 7'd126;
  localparam logic [6:0] LEN_EXT64 = 7'd127;

  // one result word from the parser to the output register
  typedef struct packed {
    logic              vld;
    logic [ByteW-1:0]  payload_byte;
    logic [OpcW-1:0]   frame_opcode;
    logic              was_masked;
    logic              frame_end;
    logic              empty_frame;
  } wsd_res_t;

endpackage

`default_nettype wire

/* sv/wsd_parse.sv */
`timescale 1ns / 1ps
`default_nettype none

module wsd_parse (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  input  wire logic                       take,
  input  wire logic [wsd_pkg::ByteW-1:0]  rx_byte,
  output wsd_pkg::wsd_res_t               res
);

  typedef enum logic [2:0] {
    PH_HDR0  = 3'd0,
    PH_HDR1  = 3'd1,
    PH_EXT16 = 3'd2,
    PH_EXT64 = 3'd3,
    PH_KEY   = 3'd4,
    PH_DATA  = 3'd5
  } phase_t;

  phase_t                     phase_r, phase_nxt;
  logic [wsd_pkg::OpcW-1:0]   opc_r, opc_nxt;
  logic                       mask_r, mask_nxt;
  logic [wsd_pkg::LenW-1:0]   rem_r, rem_nxt;
  logic [2:0]                 hcnt_r, hcnt_nxt;
  logic [wsd_pkg::ByteW-1:0]  key_r [4];
  logic [wsd_pkg::ByteW-1:0]  key_nxt [4];
  logic [1:0]                 kidx_r, kidx_nxt;

  always_comb begin
    logic [2:0]                hinc;
    logic [wsd_pkg::LenW-1:0]  rdec;
    logic                      len_done;
    logic                      key_done;

    phase_nxt = phase_r;
    opc_nxt   = opc_r;
    mask_nxt  = mask_r;
    rem_nxt   = rem_r;
    hcnt_nxt  = hcnt_r;
    key_nxt   = key_r;
    kidx_nxt  = kidx_r;
    hinc      = hcnt_r + 3'd1;
    rdec      = rem_r - {{(wsd_pkg::LenW-1){1'b0}}, 1'b1};
    len_done  = 1'b0;
    key_done  = 1'b0;
    res       = '0;

    case (phase_r)
      PH_HDR1: begin
        mask_nxt = rx_byte[7];
        hcnt_nxt = 3'd0;
        rem_nxt  = '0;
        if (!rx_byte[7]) begin
          for (int i = 0; i < 4; i++) key_nxt[i] = '0;
        end
        if (rx_byte[6:0] == wsd_pkg::LEN_EXT16) begin
          phase_nxt = PH_EXT16;
        end else if (rx_byte[6:0] == wsd_pkg::LEN_EXT64) begin
          phase_nxt = PH_EXT64;
        end else begin
          rem_nxt  = {{(wsd_pkg::LenW-7){1'b0}}, rx_byte[6:0]};
          len_done = 1'b1;
        end
      end
      PH_EXT16, PH_EXT64: begin
        rem_nxt  = {rem_r[wsd_pkg::LenW-9:0], rx_byte};
        hcnt_nxt = hinc;
        if ((phase_r == PH_EXT16 && hinc == 3'd2) ||
            (phase_r == PH_EXT64 && hinc == 3'd0)) begin
          len_done = 1'b1;
        end
      end
      PH_KEY: begin
        key_nxt[hcnt_r[1:0]] = rx_byte;
        hcnt_nxt = hinc;
        if (hinc >= 3'd4) begin
          hcnt_nxt = 3'd0;
          key_done = 1'b1;
        end
      end
      PH_DATA: begin
        res.vld          = 1'b1;
        res.payload_byte = rx_byte ^ key_r[kidx_r];
        kidx_nxt         = kidx_r + 2'd1;
        rem_nxt          = rdec;
        if (rdec == '0) begin
          phase_nxt     = PH_HDR0;
          res.frame_end = 1'b1;
        end
      end
      default: begin
        opc_nxt   = rx_byte[wsd_pkg::OpcW-1:0];
        phase_nxt = PH_HDR1;
      end
    endcase

    // length or key known: collect the key, or go to payload / mark empty frame
    if (len_done && mask_nxt) begin
      hcnt_nxt  = 3'd0;
      phase_nxt = PH_KEY;
    end else if (len_done || key_done) begin
      kidx_nxt = 2'd0;
      if (rem_nxt == '0) begin
        phase_nxt       = PH_HDR0;
        res.vld         = 1'b1;
        res.frame_end   = 1'b1;
        res.empty_frame = 1'b1;
      end else begin
        phase_nxt = PH_DATA;
      end
    end

    res.frame_opcode = opc_r;
    res.was_masked   = mask_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_HDR0;
      opc_r   <= '0;
      mask_r  <= 1'b0;
      rem_r   <= '0;
      hcnt_r  <= '0;
      kidx_r  <= '0;
      for (int i = 0; i < 4; i++) key_r[i] <= '0;
    end else if (take) begin
      phase_r <= phase_nxt;
      opc_r   <= opc_nxt;
      mask_r  <= mask_nxt;
      rem_r   <= rem_nxt;
      hcnt_r  <= hcnt_nxt;
      kidx_r  <= kidx_nxt;
      for (int i = 0; i < 4; i++) key_r[i] <= key_nxt[i];
    end
  end

endmodule

`default_nettype wire

/* sv/websocket_frame_deframer.sv */
// Output: a payload word or empty-frame marker appears on out_valid in the cycle after
//   the input byte that causes it is accepted.
// Throughput: one byte per cycle while in_stall is low; the parser state updates in the
//   accept cycle and the output register is refilled in the same cycle it drains.
// Reset: synchronous active-low rst_n returns to awaiting the first header byte and
//   clears length, key and output valid.
`timescale 1ns / 1ps
`default_nettype none

module websocket_frame_deframer (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  input  wire logic                       in_valid,
  output wire logic                       in_stall,
  input  wire logic [wsd_pkg::ByteW-1:0]  in_rx_byte,
  output wire logic                       out_valid,
  input  wire logic                       out_stall,
  output wire logic [wsd_pkg::ByteW-1:0]  out_payload_byte,
  output wire logic [wsd_pkg::OpcW-1:0]   out_frame_opcode,
  output wire logic                       out_was_masked,
  output wire logic                       out_frame_end,
  output wire logic                       out_empty_frame
);

  wsd_pkg::wsd_res_t  res;
  wsd_pkg::wsd_res_t  out_r;
  logic               out_valid_r, out_valid_nxt;
  logic               take;
  logic               load;

  // hold input only while a result word waits downstream
  assign in_stall = out_valid_r & out_stall;
  assign take     = in_valid & ~in_stall;
  assign load     = take & res.vld;

  wsd_parse u_parse (
    .clk     (clk),
    .rst_n   (rst_n),
    .take    (take),
    .rx_byte (in_rx_byte),
    .res     (res)
  );

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (load) begin
      out_valid_nxt = 1'b1;
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      out_r <= res;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_payload_byte = out_r.payload_byte;
  assign out_frame_opcode = out_r.frame_opcode;
  assign out_was_masked   = out_r.was_masked;
  assign out_frame_end    = out_r.frame_end;
  assign out_empty_frame  = out_r.empty_frame;

  a_empty_is_end: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_r.empty_frame |-> out_r.frame_end && out_r.payload_byte == '0)
    else $error("empty-frame marker without frame_end or with data");

  a_load_shows: assert property (@(posedge clk) disable iff (!rst_n)
    load |=> out_valid_r)
    else $error("result word lost after load");

  a_drain_clears: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && !out_stall && !load |=> !out_valid_r)
    else $error("result word repeated after drain");

endmodule

`default_nettype wire

/* tb/sv/websocket_frame_deframer_tb.sv */
`timescale 1ns / 1ps

module websocket_frame_deframer_tb;

  localparam int BYTE_W = wsd_pkg::ByteW;
  localparam int OPC_W = wsd_pkg::OpcW;
  localparam int LEN_W = wsd_pkg::LenW;

  localparam int CYCLE_LIMIT = 200000;
  localparam int DRAIN_CYCLES = 5;
  localparam int LONG_HOLD_AT = 300;
  localparam int LONG_HOLD_CYCLES = 300;

  typedef enum logic [2:0] {
    ST_HDR0, ST_HDR1, ST_EXT16, ST_EXT64, ST_KEY, ST_DATA
  } parse_state_t;

  typedef enum int {FORM_SHORT, FORM_EXT16, FORM_EXT64} len_form_t;

  typedef struct {
    logic              pause;
    logic [BYTE_W-1:0] data;
  } feed_item_t;

  typedef struct {
    logic [BYTE_W-1:0] payload_byte;
    logic [OPC_W-1:0]  frame_opcode;
    logic              was_masked;
    logic              frame_end;
    logic              empty_frame;
  } frame_word_t;

  logic              clk = 1'b0;
  logic              rst_n = 1'b0;
  logic              in_valid = 1'b0;
  logic              in_stall;
  logic [BYTE_W-1:0] in_rx_byte = '0;
  logic              out_valid;
  logic              out_stall = 1'b0;
  logic [BYTE_W-1:0] out_payload_byte;
  logic [OPC_W-1:0]  out_frame_opcode;
  logic              out_was_masked;
  logic              out_frame_end;
  logic              out_empty_frame;

  feed_item_t  pending_bytes[$];
  frame_word_t exp_words[$];

  // parser state mirrored by the predictor
  parse_state_t      ph = ST_HDR0;
  logic [OPC_W-1:0]  opc_r = '0;
  logic              masked_r = 1'b0;
  logic [LEN_W-1:0]  rem_len = '0;
  logic [2:0]        hdr_cnt = '0;
  logic [BYTE_W-1:0] key_r [4] = '{default: '0};
  logic [1:0]        key_idx = '0;

  int   fail_cnt = 0;
  int   cycle_cnt = 0;
  int   in_count = 0;
  int   gap_cnt = 0;
  int   hold_cnt = 0;
  bit   in_taken = 1'b0;
  bit   calm_tx = 1'b0;
  bit   calm_rx = 1'b0;
  bit   long_done = 1'b0;
  logic drv_valid;
  logic [BYTE_W-1:0] drv_byte;
  int   rx_pick;

  always #5 clk = ~clk;

  websocket_frame_deframer u_dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_rx_byte       (in_rx_byte),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_payload_byte (out_payload_byte),
    .out_frame_opcode (out_frame_opcode),
    .out_was_masked   (out_was_masked),
    .out_frame_end    (out_frame_end),
    .out_empty_frame  (out_empty_frame)
  );

  task automatic push_word(input logic [BYTE_W-1:0] data, input logic last,
                           input logic empty);
    exp_words.insert(exp_words.size(), '{data, opc_r, masked_r, last, empty});
  endtask

  task automatic start_payload();
    key_idx = '0;
    if (rem_len == '0) begin
      ph = ST_HDR0;
      push_word('0, 1'b1, 1'b1);
    end else begin
      ph = ST_DATA;
    end
  endtask

  task automatic close_length();
    if (masked_r) begin
      hdr_cnt = '0;
      ph = ST_KEY;
    end else begin
      start_payload();
    end
  endtask

  task automatic deframe_byte(input logic [BYTE_W-1:0] b);
    logic [BYTE_W-1:0] data;
    case (ph)
      ST_HDR1: begin
        masked_r = b[7];
        if (!b[7]) key_r = '{default: '0};
        hdr_cnt = '0;
        rem_len = '0;
        if (b[6:0] == wsd_pkg::LEN_EXT16) ph = ST_EXT16;
        else if (b[6:0] == wsd_pkg::LEN_EXT64) ph = ST_EXT64;
        else begin
          rem_len = LEN_W'(b[6:0]);
          close_length();
        end
      end
      ST_EXT16, ST_EXT64: begin
        rem_len = {rem_len[LEN_W-9:0], b};
        hdr_cnt = hdr_cnt + 3'd1;
        if ((ph == ST_EXT16 && hdr_cnt == 3'd2) || (ph == ST_EXT64 && hdr_cnt == 3'd0))
          close_length();
      end
      ST_KEY: begin
        key_r[hdr_cnt[1:0]] = b;
        hdr_cnt = hdr_cnt + 3'd1;
        if (hdr_cnt >= 3'd4) begin
          hdr_cnt = '0;
          start_payload();
        end
      end
      ST_DATA: begin
        data = b ^ key_r[key_idx];
        key_idx = key_idx + 2'd1;
        rem_len = rem_len - LEN_W'(1);
        if (rem_len == '0) begin
          ph = ST_HDR0;
          push_word(data, 1'b1, 1'b0);
        end else begin
          push_word(data, 1'b0, 1'b0);
        end
      end
      default: begin
        opc_r = b[3:0];
        ph = ST_HDR1;
      end
    endcase
  endtask

  task automatic put_byte(input logic [BYTE_W-1:0] b);
    pending_bytes.insert(pending_bytes.size(), '{1'b0, b});
  endtask

  task automatic add_frame(input logic [BYTE_W-1:0] b0, input logic masked,
                           input len_form_t form, input logic [LEN_W-1:0] len,
                           input int n_data, input logic [31:0] key);
    put_byte(b0);
    case (form)
      FORM_SHORT: put_byte({masked, len[6:0]});
      FORM_EXT16: begin
        put_byte({masked, wsd_pkg::LEN_EXT16});
        put_byte(len[15:8]);
        put_byte(len[7:0]);
      end
      default: begin
        put_byte({masked, wsd_pkg::LEN_EXT64});
        for (int i = 7; i >= 0; i--) put_byte(len[8*i +: 8]);
      end
    endcase
    if (masked)
      for (int i = 3; i >= 0; i--) put_byte(key[8*i +: 8]);
    for (int i = 0; i < n_data; i++) put_byte(8'($urandom));
  endtask

  function automatic int pick_gap(inout bit calm);
    int r;
    if ($urandom_range(0, 149) == 0) calm = !calm;
    r = $urandom_range(0, 99);
    if (calm || r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(4, 25);
  endfunction

  // sender: hold an offered word until taken, then gap or advance
  always @(negedge clk) begin
    drv_valid = 1'b0;
    drv_byte = in_rx_byte;
    if (!rst_n) begin
      drv_valid = 1'b0;
    end else if (in_valid && !in_taken) begin
      drv_valid = 1'b1;
    end else begin
      if (in_taken) begin
        in_taken = 1'b0;
        gap_cnt = pick_gap(calm_tx);
      end
      if (gap_cnt > 0) begin
        gap_cnt--;
      end else if (pending_bytes.size() > 0) begin
        if (pending_bytes[0].pause) begin
          if (exp_words.size() == 0) void'(pending_bytes.pop_front());
        end else begin
          drv_valid = 1'b1;
          drv_byte = pending_bytes[0].data;
          void'(pending_bytes.pop_front());
        end
      end
    end
    in_valid <= drv_valid;
    in_rx_byte <= drv_byte;
  end

  // receiver: random stalls plus one long hold-off to back up the input
  always @(negedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else if (hold_cnt > 0) begin
      hold_cnt--;
      out_stall <= 1'b1;
    end else if (!long_done && in_count >= LONG_HOLD_AT) begin
      long_done = 1'b1;
      hold_cnt = LONG_HOLD_CYCLES;
      out_stall <= 1'b1;
    end else begin
      rx_pick = pick_gap(calm_rx);
      if (rx_pick == 0) begin
        out_stall <= 1'b0;
      end else begin
        hold_cnt = rx_pick - 1;
        out_stall <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin
    frame_word_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (exp_words.size() == 0) begin
        $error("unexpected word: payload_byte %02h opcode %0h", out_payload_byte,
               out_frame_opcode);
        fail_cnt++;
      end else begin
        want = exp_words.pop_front();
        if (out_payload_byte !== want.payload_byte) begin
          $error("payload_byte: expected %02h, got %02h", want.payload_byte, out_payload_byte);
          fail_cnt++;
        end
        if (out_frame_opcode !== want.frame_opcode) begin
          $error("frame_opcode: expected %0h, got %0h", want.frame_opcode, out_frame_opcode);
          fail_cnt++;
        end
        if (out_was_masked !== want.was_masked) begin
          $error("was_masked: expected %0b, got %0b", want.was_masked, out_was_masked);
          fail_cnt++;
        end
        if (out_frame_end !== want.frame_end) begin
          $error("frame_end: expected %0b, got %0b", want.frame_end, out_frame_end);
          fail_cnt++;
        end
        if (out_empty_frame !== want.empty_frame) begin
          $error("empty_frame: expected %0b, got %0b", want.empty_frame, out_empty_frame);
          fail_cnt++;
        end
      end
    end
    if (rst_n && in_valid && !in_stall) begin
      deframe_byte(in_rx_byte);
      in_count++;
      in_taken = 1'b1;
    end
  end

  always @(posedge clk) begin
    cycle_cnt++;
    if (cycle_cnt >= CYCLE_LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  initial begin
    int r;
    len_form_t form;
    logic [LEN_W-1:0] len;
    bit paused;
    paused = 1'b0;

    // zero-length frames: short, masked, non-minimal 16-bit
    add_frame(8'h89, 1'b0, FORM_SHORT, '0, 0, 32'h0);
    add_frame(8'h00, 1'b1, FORM_SHORT, '0, 0, 32'hFFFF_FFFF);
    add_frame(8'h8A, 1'b0, FORM_EXT16, '0, 0, 32'h0);
    // FIN/RSV set, 64-bit length of one, masked
    add_frame(8'hFF, 1'b1, FORM_EXT64, LEN_W'(1), 1, 32'h00FF_A55A);
    // unmasked right after masked: key must be dropped
    add_frame(8'h71, 1'b0, FORM_SHORT, LEN_W'(2), 2, 32'h0);
    add_frame(8'h02, 1'b1, FORM_SHORT, LEN_W'(5), 5, 32'hA55A_0FF0);
    add_frame(8'h81, 1'b0, FORM_EXT16, LEN_W'(1), 1, 32'h0);

    while (pending_bytes.size() < 590) begin
      r = $urandom_range(0, 99);
      if (r < 10) begin
        form = FORM_SHORT;
        len = '0;
      end else if (r < 70) begin
        form = FORM_SHORT;
        len = LEN_W'($urandom_range(1, 12));
      end else if (r < 80) begin
        form = FORM_SHORT;
        len = LEN_W'($urandom_range(13, 125));
      end else if (r < 90) begin
        form = FORM_EXT16;
        len = ($urandom_range(0, 9) == 0) ? LEN_W'($urandom_range(126, 300))
                                          : LEN_W'($urandom_range(0, 24));
      end else begin
        form = FORM_EXT64;
        len = LEN_W'($urandom_range(0, 16));
      end
      add_frame(8'($urandom), $urandom_range(0, 2) != 0, form, len, int'(len), $urandom);
      if (!paused && pending_bytes.size() > 450) begin
        paused = 1'b1;
        pending_bytes.insert(pending_bytes.size(), '{1'b1, '0});
      end
    end
    // huge 64-bit length with the top bit set; never completes
    add_frame(8'h82, 1'b1, FORM_EXT64, 64'h8000_0000_0000_0005, 40, $urandom);

    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    do @(negedge clk);
    while (pending_bytes.size() > 0 || in_valid || exp_words.size() > 0);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (fail_cnt == 0) $display("Simulation PASSED");
    else $display("Simulation FAILED");
    $finish;
  end

endmodule
